// ===== src/tft_pkg.sv =====
`default_nettype none
package tft_pkg;

  localparam int POS_BITS = 24;
  localparam int LEN_BITS = 16;
  localparam int WIN_BITS = 64;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  localparam logic [WIN_BITS-1:0] WORD_TEMPLATE = 64'h7465_6D70_6C61_7465;
  localparam logic [39:0]         WORD_ARRAY    = 40'h61_7272_6179;
  localparam logic [LEN_BITS-1:0] LEN_TEMPLATE  = LEN_BITS'(8);
  localparam logic [LEN_BITS-1:0] LEN_ARRAY     = LEN_BITS'(5);

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;

  localparam logic [3:0] KIND_LBRACE     = 4'd0;
  localparam logic [3:0] KIND_RBRACE     = 4'd1;
  localparam logic [3:0] KIND_COMMA      = 4'd2;
  localparam logic [3:0] KIND_SEMI       = 4'd3;
  localparam logic [3:0] KIND_TEMPLATE   = 4'd4;
  localparam logic [3:0] KIND_ARRAY      = 4'd5;
  localparam logic [3:0] KIND_IDENT      = 4'd6;
  localparam logic [3:0] KIND_UUID       = 4'd7;
  localparam logic [3:0] KIND_BRACKETS   = 4'd8;
  localparam logic [3:0] KIND_STRING     = 4'd9;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_UUID    = 3'd2,
    MODE_BRACKET = 3'd3,
    MODE_BRWORD  = 3'd4,
    MODE_STRING  = 3'd5
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic [POS_BITS-1:0] token_start;
    logic [LEN_BITS-1:0] token_length;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  tok0;
    out_item_t  tok1;
  } tok_pair_t;

  function automatic logic is_normal(input logic [7:0] c);
    is_normal = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39) || c == CH_PLUS || c == CH_MINUS ||
                c == CH_DOT || c == CH_USCORE;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    is_punct = c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    k = KIND_SEMI;
    if (c == CH_LBRACE) k = KIND_LBRACE;
    else if (c == CH_RBRACE) k = KIND_RBRACE;
    else if (c == CH_COMMA) k = KIND_COMMA;
    punct_kind = k;
  endfunction

endpackage
`default_nettype wire

// ===== src/tft_lexer.sv =====
`default_nettype none
module tft_lexer
  import tft_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire in_item_t  item,
  output tok_pair_t      toks
);

  lex_mode_t           mode_r,  mode_nxt;
  logic [POS_BITS-1:0] pos_r,   pos_nxt;
  logic [POS_BITS-1:0] begin_r, begin_nxt;
  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic [WIN_BITS-1:0] win_r,   win_nxt;

  logic [7:0]          c;
  logic [POS_BITS-1:0] pos_inc;
  logic [LEN_BITS-1:0] count_inc;
  logic [3:0]          word_kind;
  logic [1:0]          n;
  logic [3:0]          k0, k1;
  logic [POS_BITS-1:0] s0, s1;
  logic [LEN_BITS-1:0] l0, l1;

  assign c         = item.data_byte;
  assign pos_inc   = (pos_r == POS_MAX) ? POS_MAX : pos_r + POS_BITS'(1);
  assign count_inc = (count_r == LEN_MAX) ? LEN_MAX : count_r + LEN_BITS'(1);

  always_comb begin
    if (count_r == LEN_TEMPLATE && win_r == WORD_TEMPLATE) begin
      word_kind = KIND_TEMPLATE;
    end else if (count_r == LEN_ARRAY && win_r[39:0] == WORD_ARRAY) begin
      word_kind = KIND_ARRAY;
    end else begin
      word_kind = KIND_IDENT;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_inc;
    begin_nxt = begin_r;
    count_nxt = count_r;
    win_nxt   = win_r;
    n  = 2'd0;
    k0 = KIND_IDENT;
    s0 = begin_r;
    l0 = count_r;
    k1 = punct_kind(c);
    s1 = pos_r;
    l1 = LEN_BITS'(1);
    case (mode_r)
      MODE_IDENT: begin
        if (is_normal(c)) begin
          count_nxt = count_inc;
          win_nxt   = {win_r[WIN_BITS-9:0], c};
        end else begin
          n  = 2'd1;
          k0 = word_kind;
          if (is_punct(c)) begin
            mode_nxt = MODE_IDLE;
            n        = 2'd2;
          end else if (c == CH_LT) begin
            mode_nxt  = MODE_UUID;
            begin_nxt = pos_inc;
            count_nxt = '0;
          end else if (c == CH_LSQUARE) begin
            mode_nxt  = MODE_BRACKET;
            begin_nxt = pos_inc;
            count_nxt = '0;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_UUID: begin
        if (c == CH_GT) begin
          mode_nxt = MODE_IDLE;
          n        = 2'd1;
          k0       = KIND_UUID;
        end else begin
          count_nxt = count_inc;
        end
      end
      MODE_BRACKET, MODE_BRWORD: begin
        if (c == CH_RSQUARE) begin
          mode_nxt = MODE_IDLE;
          n        = 2'd1;
          k0       = KIND_BRACKETS;
        end else if (is_normal(c)) begin
          count_nxt = count_inc;
          mode_nxt  = MODE_BRWORD;
        end else begin
          mode_nxt = MODE_BRACKET;
        end
      end
      MODE_STRING: begin
        if (c == CH_DQUOTE) begin
          mode_nxt = MODE_IDLE;
          n        = 2'd1;
          k0       = KIND_STRING;
        end else begin
          count_nxt = count_inc;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (is_punct(c)) begin
          n  = 2'd1;
          k0 = punct_kind(c);
          s0 = pos_r;
          l0 = LEN_BITS'(1);
        end else if (c == CH_LT) begin
          mode_nxt  = MODE_UUID;
          begin_nxt = pos_inc;
          count_nxt = '0;
        end else if (c == CH_LSQUARE) begin
          mode_nxt  = MODE_BRACKET;
          begin_nxt = pos_inc;
          count_nxt = '0;
        end else if (c == CH_DQUOTE) begin
          mode_nxt  = MODE_STRING;
          begin_nxt = pos_inc;
          count_nxt = '0;
        end else if (is_normal(c)) begin
          mode_nxt  = MODE_IDENT;
          begin_nxt = pos_r;
          count_nxt = LEN_BITS'(1);
          win_nxt   = {{(WIN_BITS-8){1'b0}}, c};
        end
      end
    endcase
    if (item.end_of_stream) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      begin_nxt = '0;
      count_nxt = '0;
      win_nxt   = '0;
    end
  end

  always_comb begin
    toks.cnt  = n;
    toks.tok0 = '{token_kind: k0, token_start: s0, token_length: l0,
                  last_of_run: (n == 2'd1)};
    toks.tok1 = '{token_kind: k1, token_start: s1, token_length: l1,
                  last_of_run: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      count_r <= '0;
      win_r   <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      count_r <= count_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/tft_tok_fifo.sv =====
`default_nettype none
module tft_tok_fifo
  import tft_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire tok_pair_t toks,
  output logic           room2,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  out_item_t  mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic       pop;

  assign room2     = cnt_r <= 3'd2;
  assign out_valid = cnt_r != 3'd0;
  assign out_item  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign n_in      = push ? toks.cnt : 2'd0;

  always_comb begin
    wr_nxt  = wr_r + n_in;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, n_in} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wr_r] <= toks.tok0;
    end
    if (n_in == 2'd2) begin
      mem_r[wr_r + 2'd1] <= toks.tok1;
    end
  end

endmodule
`default_nettype wire

// ===== src/text_format_tokenizer_core.sv =====
// Channel   Direction  Payload      Handshake
// in_       input      in_item_t    in_valid / in_stall
// out_      output     out_item_t   out_valid / out_stall
//
// One byte per cycle while in_stall is low. Each byte is registered, then
// the lexer step writes its zero, one or two tokens into a four-entry token
// queue; a token written to an empty queue shows on out_ the cycle after.
// The lexer step waits while the queue has fewer than two free entries.
// Reset is synchronous on rst_n and clears lexer state and the queue.
`default_nettype none
module text_format_tokenizer_core
  import tft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic      full_r;
  in_item_t  item_r;
  logic      adv;
  logic      room2;
  tok_pair_t toks;

  assign adv      = full_r && room2;
  assign in_stall = full_r && !room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (!in_stall) begin
      full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  tft_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .toks  (toks)
  );

  tft_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .toks      (toks),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
